@@ design/pwa_pkg.sv @@
// Shared constants and widths for the pulse waveform analyzer.
// No dependencies.
package pwa_pkg;
   localparam int FRACTION_BITS = 8;
   localparam int SAMPLE_W      = 16;
   localparam int WIN_AW        = 4;
   localparam int WIN_DEPTH     = 16;
   localparam int PSUM_W        = 20;
   localparam int SQ_W          = 40;
   localparam int SUM_W         = 28;
   localparam int SQSUM_W       = 48;
   localparam int NUM_W         = 73;
   localparam int DEN_W         = 25;
   localparam int QUO_W         = 48;
   localparam int ROOT_W        = 24;
   localparam int OUT_W         = 24;
   localparam int IDX_W         = 12;
   localparam int RSP_W         = 216;
   localparam logic [PSUM_W-1:0] LOW_START = 20'd16000;
   localparam logic [1:0] REG_EVENT_LENGTH    = 2'd0;
   localparam logic [1:0] REG_AVERAGE_WINDOW  = 2'd1;
   localparam logic [1:0] REG_BASELINE_LENGTH = 2'd2;
   localparam logic [1:0] REG_THRESHOLD       = 2'd3;
endpackage

@@ design/pwa_window_mem.sv @@
// Sample window ring memory with per-entry valid bits; unwritten entries read zero.
// Depends on pwa_pkg.
module pwa_window_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [pwa_pkg::WIN_AW-1:0]    wr_addr,
   input  logic [pwa_pkg::SAMPLE_W-1:0]  wr_data,
   input  logic [pwa_pkg::WIN_AW-1:0]    rd_addr,
   output logic [pwa_pkg::SAMPLE_W-1:0]  rd_data
);
   import pwa_pkg::*;

   logic [SAMPLE_W-1:0]  mem [WIN_DEPTH];
   logic [WIN_DEPTH-1:0] valid_ff;
   logic [SAMPLE_W-1:0]  data_ff;
   logic                 hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         hit_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;
endmodule

@@ design/pwa_divider.sv @@
// Restoring radix-2 divider, one quotient bit per cycle.
// Depends on pwa_pkg.
module pwa_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [pwa_pkg::NUM_W-1:0]  numer,
   input  logic [pwa_pkg::DEN_W-1:0]  denom,
   output logic                       done,
   output logic [pwa_pkg::QUO_W-1:0]  quot
);
   import pwa_pkg::*;

   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [6:0]       cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   trial;
   logic             ge;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      ge    = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         num_ff  <= '0;
         rem_ff  <= '0;
         den_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= numer;
            den_ff  <= denom;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            num_ff <= {num_ff[NUM_W-2:0], ge};
            cnt_ff <= cnt_ff + 7'd1;
            if (cnt_ff == 7'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quot = num_ff[QUO_W-1:0];
endmodule

@@ design/pwa_sqrt.sv @@
// Integer square root, two radicand bits per cycle.
// Depends on pwa_pkg.
module pwa_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pwa_pkg::QUO_W-1:0]   radicand,
   output logic                        done,
   output logic [pwa_pkg::ROOT_W-1:0]  root
);
   import pwa_pkg::*;

   logic [QUO_W-1:0]    val_ff;
   logic [ROOT_W+1:0]   rem_ff;
   logic [ROOT_W-1:0]   root_ff;
   logic [4:0]          cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [ROOT_W+3:0]   rem_sh;
   logic [ROOT_W+3:0]   trial;
   logic                ge;

   always_comb begin
      rem_sh = {rem_ff, val_ff[QUO_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      ge     = rem_sh >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         val_ff  <= '0;
         rem_ff  <= '0;
         root_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            val_ff  <= radicand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff  <= ge ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
            root_ff <= {root_ff[ROOT_W-2:0], ge};
            val_ff  <= {val_ff[QUO_W-3:0], 2'b00};
            cnt_ff  <= cnt_ff + 5'd1;
            if (cnt_ff == 5'(ROOT_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

@@ design/pulse_waveform_analyzer.sv @@
// Pulse waveform analyzer: boxcar average, peak, minimum, trigger, baseline and tail statistics.
// One request at a time; a request that yields a point sums its window of w samples
// (w = window) by reading the sample ring one entry a cycle, then squares and updates.
// After the last point the result is built from six rounded divides and two RMS jobs
// (73-step divide, 24-step root), then offered from the output state.
// Synchronous reset restores register defaults and starts a fresh event; ring reads zero.
// Depends on pwa_pkg, pwa_window_mem, pwa_divider, pwa_sqrt.
module pulse_waveform_analyzer (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [15:0]                 req_tdata,  // sample[15:0]
   input  logic                        req_tuser,  // event_start
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // base_mean, base_rms, base_high, base_low, tail_mean, tail_rms, max_value,
   // min_value (24 each), min_index, trigger_index (12 each)
   output logic [pwa_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_addr,
   input  logic [15:0]                 csr_wdata
);
   import pwa_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0, S_STEP = 4'd1, S_SUM = 4'd2, S_SQ = 4'd3,
                          S_UPD = 4'd4, S_FSET = 4'd5, S_FSUB = 4'd6, S_DGO = 4'd7,
                          S_DIV = 4'd8, S_SQRT = 4'd9, S_OUT = 4'd10;
   localparam logic [2:0] J_BMEAN = 3'd0, J_BRMS = 3'd1, J_BHIGH = 3'd2, J_BLOW = 3'd3,
                          J_TMEAN = 3'd4, J_TRMS = 3'd5, J_MAX = 3'd6, J_MIN = 3'd7;

   logic [12:0] cfg_len_ff;
   logic [4:0]  cfg_win_ff;
   logic [8:0]  cfg_base_ff;
   logic [15:0] cfg_thr_ff;

   logic [3:0]           state_ff;
   logic [SAMPLE_W-1:0]  samp_ff;
   logic [WIN_AW-1:0]    wr_ptr_ff;
   logic [WIN_AW-1:0]    rd_addr;
   logic [4:0]           iss_ff;
   logic                 pend_ff;
   logic [PSUM_W-1:0]    acc_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [12:0]          raw_ff;
   logic [12:0]          point_ff;
   logic                 finished_ff;
   logic [SUM_W-1:0]     hsum_ff, tsum_ff;
   logic [SQSUM_W-1:0]   hsq_ff, tsq_ff;
   logic [PSUM_W-1:0]    hhigh_ff, hlow_ff, ohigh_ff, olow_ff;
   logic [IDX_W-1:0]     lowpos_ff, trigpos_ff;
   logic [2:0]           job_ff;
   logic [56:0]          proda_ff;
   logic [55:0]          prodc_ff;
   logic [DEN_W-1:0]     d2_ff;
   logic [NUM_W-1:0]     div_num_ff;
   logic [DEN_W-1:0]     div_den_ff;
   logic [OUT_W-1:0]     res_ff [8];
   logic                 rsp_valid_ff;
   logic [RSP_W-1:0]     rsp_data_ff;

   logic [4:0]   win_eff;
   logic [12:0]  len_eff;
   logic [8:0]   base_b0, base_b1, base_eff;
   logic [12:0]  bw;
   logic [12:0]  raw_in;
   logic [12:0]  point_in;
   logic [20:0]  thr_w;
   logic [PSUM_W-1:0] low_init;
   logic [SUM_W-1:0]  s_sel;
   logic [12:0]       d_sel;
   logic [36:0]       scaled_num;
   logic [56:0]       rms_num;
   logic              rms_job;
   logic [SQSUM_W-1:0] sq_sel;
   logic [SAMPLE_W-1:0] rd_data;
   logic              mem_we;
   logic              div_start, div_done, sqrt_start, sqrt_done;
   logic [QUO_W-1:0]  quot;
   logic [ROOT_W-1:0] root;

   always_comb begin
      win_eff  = (cfg_win_ff == 5'd0) ? 5'd1 : ((cfg_win_ff > 5'd16) ? 5'd16 : cfg_win_ff);
      len_eff  = (cfg_len_ff == 13'd0) ? 13'd1 :
                 ((cfg_len_ff > 13'd4096) ? 13'd4096 : cfg_len_ff);
      base_b0  = (cfg_base_ff == 9'd0) ? 9'd1 : cfg_base_ff;
      base_b1  = (base_b0 > 9'd256) ? 9'd256 : base_b0;
      base_eff = ({4'b0, base_b1} > len_eff) ? len_eff[8:0] : base_b1;
      bw       = {4'b0, base_eff} * {8'b0, win_eff};
      raw_in   = (raw_ff == 13'h1FFF) ? raw_ff : raw_ff + 13'd1;
      point_in = point_ff + 13'd1;
      thr_w    = {5'b0, cfg_thr_ff} * {16'b0, win_eff};
      low_init = 20'(LOW_START * win_eff);
      rd_addr  = wr_ptr_ff - 4'd1 - iss_ff[WIN_AW-1:0];
      mem_we   = (state_ff == S_STEP) && !finished_ff && (point_ff < len_eff);
      rms_job  = (job_ff == J_BRMS) || (job_ff == J_TRMS);
      case (job_ff) inside
         J_BMEAN, J_BRMS: begin s_sel = hsum_ff; d_sel = bw; end
         J_BHIGH:         begin s_sel = {8'b0, hhigh_ff}; d_sel = {8'b0, win_eff}; end
         J_BLOW:          begin s_sel = {8'b0, hlow_ff}; d_sel = {8'b0, win_eff}; end
         J_TMEAN, J_TRMS: begin s_sel = tsum_ff; d_sel = bw; end
         J_MAX:           begin s_sel = {8'b0, ohigh_ff}; d_sel = {8'b0, win_eff}; end
         default:         begin s_sel = {8'b0, olow_ff}; d_sel = {8'b0, win_eff}; end
      endcase
      sq_sel     = (job_ff == J_BRMS) ? hsq_ff : tsq_ff;
      scaled_num = {1'b0, s_sel, {FRACTION_BITS{1'b0}}} + 37'(d_sel >> 1);
      rms_num    = (proda_ff > {1'b0, prodc_ff}) ? proda_ff - {1'b0, prodc_ff} : '0;
      div_start  = (state_ff == S_DGO);
      sqrt_start = (state_ff == S_DIV) && div_done && rms_job;
   end

   assign req_tready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff  <= 13'd1024;
         cfg_win_ff  <= 5'd1;
         cfg_base_ff <= 9'd32;
         cfg_thr_ff  <= 16'd0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_EVENT_LENGTH:    cfg_len_ff  <= csr_wdata[12:0];
            REG_AVERAGE_WINDOW:  cfg_win_ff  <= csr_wdata[4:0];
            REG_BASELINE_LENGTH: cfg_base_ff <= csr_wdata[8:0];
            REG_THRESHOLD:       cfg_thr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wr_ptr_ff    <= '0;
         raw_ff       <= '0;
         point_ff     <= '0;
         finished_ff  <= 1'b0;
         hsum_ff      <= '0;
         tsum_ff      <= '0;
         hsq_ff       <= '0;
         tsq_ff       <= '0;
         hhigh_ff     <= '0;
         ohigh_ff     <= '0;
         hlow_ff      <= LOW_START;
         olow_ff      <= LOW_START;
         lowpos_ff    <= '0;
         trigpos_ff   <= '0;
         iss_ff       <= '0;
         pend_ff      <= 1'b0;
         job_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  samp_ff  <= req_tdata;
                  state_ff <= S_STEP;
                  if (req_tuser) begin
                     raw_ff      <= '0;
                     point_ff    <= '0;
                     finished_ff <= 1'b0;
                     hsum_ff     <= '0;
                     tsum_ff     <= '0;
                     hsq_ff      <= '0;
                     tsq_ff      <= '0;
                     hhigh_ff    <= '0;
                     ohigh_ff    <= '0;
                     hlow_ff     <= low_init;
                     olow_ff     <= low_init;
                     lowpos_ff   <= '0;
                     trigpos_ff  <= '0;
                  end
               end
            end
            S_STEP: begin
               if (!mem_we) begin
                  finished_ff <= 1'b1;
                  state_ff    <= S_IDLE;
               end else begin
                  wr_ptr_ff <= wr_ptr_ff + 4'd1;
                  raw_ff    <= raw_in;
                  if (raw_in < {8'b0, win_eff}) begin
                     state_ff <= S_IDLE;
                  end else begin
                     iss_ff   <= '0;
                     pend_ff  <= 1'b0;
                     acc_ff   <= '0;
                     state_ff <= S_SUM;
                  end
               end
            end
            S_SUM: begin
               pend_ff <= (iss_ff < win_eff);
               if (iss_ff < win_eff) begin
                  iss_ff <= iss_ff + 5'd1;
               end
               if (pend_ff) begin
                  acc_ff <= acc_ff + {4'b0, rd_data};
               end
               if (!(iss_ff < win_eff) && !pend_ff) begin
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               sq_ff    <= acc_ff * acc_ff;
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (acc_ff > ohigh_ff) ohigh_ff <= acc_ff;
               if (point_ff < {4'b0, base_eff}) begin
                  hsum_ff <= hsum_ff + {8'b0, acc_ff};
                  hsq_ff  <= hsq_ff + {8'b0, sq_ff};
                  if (acc_ff > hhigh_ff) hhigh_ff <= acc_ff;
                  if (acc_ff < hlow_ff) hlow_ff <= acc_ff;
               end
               if (point_ff >= len_eff - {4'b0, base_eff}) begin
                  tsum_ff <= tsum_ff + {8'b0, acc_ff};
                  tsq_ff  <= tsq_ff + {8'b0, sq_ff};
               end
               if (acc_ff < olow_ff) begin
                  olow_ff   <= acc_ff;
                  lowpos_ff <= point_ff[IDX_W-1:0];
               end
               if ((trigpos_ff == '0) && ({1'b0, acc_ff} < thr_w)) begin
                  trigpos_ff <= point_ff[IDX_W-1:0];
               end
               point_ff <= point_in;
               if (point_in < len_eff) begin
                  state_ff <= S_IDLE;
               end else begin
                  finished_ff <= 1'b1;
                  job_ff      <= J_BMEAN;
                  state_ff    <= S_FSET;
               end
            end
            S_FSET: begin
               if (rms_job) begin
                  proda_ff <= {48'b0, base_eff} * {9'b0, sq_sel};
                  prodc_ff <= s_sel * s_sel;
                  d2_ff    <= {12'b0, bw} * {12'b0, bw};
                  state_ff <= S_FSUB;
               end else begin
                  div_num_ff <= {36'b0, scaled_num};
                  div_den_ff <= {12'b0, d_sel};
                  state_ff   <= S_DGO;
               end
            end
            S_FSUB: begin
               div_num_ff <= {rms_num, {2*FRACTION_BITS{1'b0}}};
               div_den_ff <= d2_ff;
               state_ff   <= S_DGO;
            end
            S_DGO: begin
               state_ff <= S_DIV;
            end
            S_DIV: begin
               if (div_done) begin
                  if (rms_job) begin
                     state_ff <= S_SQRT;
                  end else begin
                     res_ff[job_ff] <= quot[OUT_W-1:0];
                     job_ff   <= job_ff + 3'd1;
                     state_ff <= (job_ff == J_MIN) ? S_OUT : S_FSET;
                  end
               end
            end
            S_SQRT: begin
               if (sqrt_done) begin
                  res_ff[job_ff] <= root;
                  job_ff   <= job_ff + 3'd1;
                  state_ff <= S_FSET;
               end
            end
            S_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_data_ff  <= {trigpos_ff, lowpos_ff, res_ff[7], res_ff[6], res_ff[5],
                                   res_ff[4], res_ff[3], res_ff[2], res_ff[1], res_ff[0]};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   pwa_window_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (samp_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pwa_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (div_num_ff),
      .denom (div_den_ff),
      .done  (div_done),
      .quot  (quot)
   );

   pwa_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (quot),
      .done     (sqrt_done),
      .root     (root)
   );
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Testbench for pulse_waveform_analyzer: drives sample requests and register writes,
// predicts each event's statistics in-bench and checks every result word field by field.
// Depends on pwa_pkg and the pulse_waveform_analyzer RTL.
module tb;
   import pwa_pkg::*;

   localparam int LIMIT = 1500000;

   typedef struct {
      bit [23:0] val[8];
      bit [11:0] min_idx;
      bit [11:0] trig_idx;
   } stats_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [15:0] req_tdata = 0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_W-1:0] rsp_tdata;
   logic csr_we = 0;
   logic [1:0] csr_addr = 0;
   logic [15:0] csr_wdata = 0;

   pulse_waveform_analyzer DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   int errors = 0;
   int cycles = 0;
   int sent_items = 0;
   int results_seen = 0;
   bit idling = 1;
   int hold_cycles = 0;
   stats_type expected_stats[$];

   // shadow registers and event state
   bit [63:0] r_len, r_win, r_base, r_thr;
   bit [15:0] ring[16];
   bit [63:0] raw_cnt, pt_idx;
   bit [63:0] h_sum, h_sq, t_sum, t_sq, h_high, h_low, o_high, o_low, low_pos, trig_pos;
   bit done_evt;

   function automatic bit [63:0] win_eff();
      if (r_win == 0) return 1;
      if (r_win > 16) return 16;
      return r_win;
   endfunction

   function automatic bit [63:0] len_eff();
      if (r_len == 0) return 1;
      if (r_len > 4096) return 4096;
      return r_len;
   endfunction

   function automatic bit [63:0] base_eff();
      bit [63:0] b;
      b = (r_base == 0) ? 64'd1 : r_base;
      if (b > 256) b = 256;
      if (b > len_eff()) b = len_eff();
      return b;
   endfunction

   function automatic void new_event();
      raw_cnt = 0; pt_idx = 0;
      h_sum = 0; h_sq = 0; t_sum = 0; t_sq = 0;
      h_high = 0; o_high = 0;
      h_low = 16000 * win_eff(); o_low = 16000 * win_eff();
      low_pos = 0; trig_pos = 0;
      done_evt = 0;
   endfunction

   function automatic bit [63:0] int_sqrt(input bit [63:0] v);
      bit [63:0] r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic bit [63:0] fixed_div(input bit [63:0] s, input bit [63:0] d);
      return ((s << FRACTION_BITS) + d / 2) / d;
   endfunction

   function automatic bit [63:0] rms_dev(input bit [63:0] s, input bit [63:0] s2,
                                         input bit [63:0] b, input bit [63:0] w);
      bit [63:0] a, c, num, d2, q;
      a = b * s2; c = s * s;
      num = (a > c) ? a - c : 64'd0;
      d2 = (b * w) * (b * w);
      q = ((num / d2) << (2 * FRACTION_BITS)) + (((num % d2) << (2 * FRACTION_BITS)) / d2);
      return int_sqrt(q);
   endfunction

   function automatic bit analyze_sample(input bit [15:0] s, input bit st,
                                         output stats_type r);
      bit [63:0] w, len, b, p, i;
      if (st) new_event();
      len = len_eff();
      if (done_evt || pt_idx >= len) begin
         done_evt = 1;
         return 0;
      end
      w = win_eff();
      b = base_eff();
      for (int k = 15; k > 0; k--) ring[k] = ring[k-1];
      ring[0] = s;
      if (raw_cnt < 64'h1FFF) raw_cnt++;
      if (raw_cnt < w) return 0;
      p = 0;
      for (int k = 0; k < w; k++) p += {48'b0, ring[k]};
      i = pt_idx;
      if (p > o_high) o_high = p;
      if (i < b) begin
         h_sum += p; h_sq += p * p;
         if (p > h_high) h_high = p;
         if (p < h_low) h_low = p;
      end
      if (i >= len - b) begin
         t_sum += p; t_sq += p * p;
      end
      if (p < o_low) begin
         o_low = p; low_pos = i;
      end
      if (trig_pos == 0 && p < r_thr * w) trig_pos = i;
      pt_idx = i + 1;
      if (pt_idx < len) return 0;
      done_evt = 1;
      r.val[0] = 24'(fixed_div(h_sum, b * w));
      r.val[1] = 24'(rms_dev(h_sum, h_sq, b, w));
      r.val[2] = 24'(fixed_div(h_high, w));
      r.val[3] = 24'(fixed_div(h_low, w));
      r.val[4] = 24'(fixed_div(t_sum, b * w));
      r.val[5] = 24'(rms_dev(t_sum, t_sq, b, w));
      r.val[6] = 24'(fixed_div(o_high, w));
      r.val[7] = 24'(fixed_div(o_low, w));
      r.min_idx = low_pos[11:0];
      r.trig_idx = trig_pos[11:0];
      return 1;
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // result consumer
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 0;
            hold_cycles--;
         end else if (stall > 0) begin
            rsp_tready <= 0;
            stall--;
         end else begin
            rsp_tready <= 1;
            if (idling && $urandom_range(0, 7) == 0) stall = $urandom_range(1, 15);
         end
      end
   end

   // result checker
   string field_name[8] = '{"base_mean", "base_rms", "base_high", "base_low",
                            "tail_mean", "tail_rms", "max_value", "min_value"};
   always @(posedge clock) begin
      stats_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (expected_stats.size() == 0) begin
            $error("unexpected result %h", rsp_tdata);
            errors++;
         end else begin
            e = expected_stats.pop_front();
            for (int j = 0; j < 8; j++)
               if (rsp_tdata[j*24 +: 24] !== e.val[j]) begin
                  $error("%s: expected %0d, got %0d", field_name[j], e.val[j],
                         rsp_tdata[j*24 +: 24]);
                  errors++;
               end
            if (rsp_tdata[192 +: 12] !== e.min_idx) begin
               $error("min_index: expected %0d, got %0d", e.min_idx, rsp_tdata[192 +: 12]);
               errors++;
            end
            if (rsp_tdata[204 +: 12] !== e.trig_idx) begin
               $error("trigger_index: expected %0d, got %0d", e.trig_idx,
                      rsp_tdata[204 +: 12]);
               errors++;
            end
         end
      end
   end

   task automatic send_request(input bit [15:0] s, input bit st);
      int gap;
      stats_type r;
      if (idling && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 15);
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= s;
      req_tuser <= st;
      do @(posedge clock); while (!req_tready);
      sent_items++;
      if (analyze_sample(s, st, r)) expected_stats.push_back(r);
   endtask

   task automatic settle();
      req_tvalid <= 0;
      while (expected_stats.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input bit [15:0] v);
      csr_we <= 1;
      csr_addr <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         REG_EVENT_LENGTH:    r_len = {48'b0, v & 16'h1FFF};
         REG_AVERAGE_WINDOW:  r_win = {48'b0, v & 16'h1F};
         REG_BASELINE_LENGTH: r_base = {48'b0, v & 16'h1FF};
         REG_THRESHOLD:       r_thr = {48'b0, v};
         default: ;
      endcase
   endtask

   task automatic set_config(input bit [15:0] len, input bit [15:0] win,
                             input bit [15:0] base, input bit [15:0] thr);
      settle();
      csr_write(REG_EVENT_LENGTH, len);
      csr_write(REG_AVERAGE_WINDOW, win);
      csr_write(REG_BASELINE_LENGTH, base);
      csr_write(REG_THRESHOLD, thr);
   endtask

   function automatic bit [15:0] pick_sample();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         1: return 16'(16000 + $urandom_range(0, 8) - 4);
         2: return 16'(r_thr[15:0] + $urandom_range(0, 6) - 3);
         default: return 16'($urandom);
      endcase
   endfunction

   // full event with random content; extra samples past the end are ignored
   task automatic send_event(input int extra);
      int n;
      n = int'(len_eff() + win_eff()) - 1 + extra;
      for (int k = 0; k < n; k++) send_request(pick_sample(), k == 0);
   endtask

   task automatic test_reset_event();
      csr_write(REG_EVENT_LENGTH, 3);
      send_request(16'd100, 0);
      send_request(16'd20000, 0);
      send_request(16'd5, 0);
   endtask

   task automatic test_directed();
      bit [15:0] seq[6] = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h1234, 16'h0001};
      // trigger on point zero still counts as none
      set_config(6, 2, 2, 16'hFFFF);
      send_request(16'h0000, 1);
      foreach (seq[k]) send_request(seq[k], 0);
      send_request(16'hFFFF, 0);
      send_request(16'hAAAA, 0);
      // widest window, all ones, zero threshold
      set_config(2, 16, 1, 0);
      for (int k = 0; k < 17; k++) send_request(16'hFFFF, k == 0);
      // out-of-range register values
      set_config(0, 31, 0, 16000);
      send_request(16'h5555, 1);
      send_request(16'h3E7F, 1);
      // length lowered under the points done
      set_config(10, 1, 4, 500);
      for (int k = 0; k < 5; k++) send_request(pick_sample(), k == 0);
      settle();
      csr_write(REG_EVENT_LENGTH, 3);
      send_request(16'h0100, 0);
      send_request(16'h0200, 0);
   endtask

   // widest window with the baseline clamped to its maximum
   task automatic test_longest_event();
      bit id;
      id = idling;
      idling = 0;
      set_config(16'd260, 16, 16'h1FF, 16'h8000);
      send_event(1);
      idling = id;
   endtask

   task automatic test_random_phases(input int target);
      int len;
      while (sent_items < target) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64) : $urandom_range(0, 12);
         set_config(16'(len), 16'($urandom_range(0, 20)),
                    ($urandom_range(0, 5) == 0) ? 16'($urandom_range(0, 511)) :
                                                  16'($urandom_range(0, len + 2)),
                    ($urandom_range(0, 1) == 0) ? 16'($urandom) :
                                                  16'(16000 + $urandom_range(0, 64)));
         repeat ($urandom_range(2, 5)) begin
            case ($urandom_range(0, 5))
               0: begin
                  for (int k = 0; k < $urandom_range(1, 4); k++)
                     send_request(pick_sample(), k == 0);
               end
               1: send_request(16'($urandom), 1'($urandom_range(0, 1)));
               default: send_event($urandom_range(0, 2));
            endcase
         end
      end
   endtask

   task automatic test_backpressure();
      set_config(2, 1, 1, 100);
      hold_cycles = 3000;
      repeat (8) send_event(0);
      settle();
   endtask

   task automatic test_pause_midrun();
      set_config(4, 3, 2, 20000);
      send_event(0);
      settle();
      send_event(0);
   endtask

   initial begin
      r_len = 1024; r_win = 1; r_base = 32; r_thr = 0;
      foreach (ring[k]) ring[k] = 0;
      new_event();
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_reset_event();
      test_directed();
      test_longest_event();
      test_backpressure();
      test_random_phases(sent_items + 50);
      test_pause_midrun();
      test_random_phases(sent_items + 25);
      idling = 0;
      test_random_phases(sent_items + 20);
      settle();
      repeat (100) @(posedge clock);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end
endmodule

@@ files.f @@
design/pwa_pkg.sv
design/pwa_window_mem.sv
design/pwa_divider.sv
design/pwa_sqrt.sv
design/pulse_waveform_analyzer.sv
bench/tb.sv
